// File: hdl/rrsi_pkg.sv
`default_nettype none

package rrsi_pkg;

    localparam int PRICE_BITS = 32;
    localparam int MAX_PERIOD = 64;

    localparam int CFG_W      = 7;
    localparam int PERIOD_RST = 14;

    localparam int PTR_W = $clog2(MAX_PERIOD);
    localparam int CNT_W = $clog2(MAX_PERIOD + 1);
    localparam int SUM_W = PRICE_BITS + $clog2(MAX_PERIOD);

    // Result scale: 100 * 256 = 25600 = 2^14 + 2^13 + 2^10.
    localparam int VAL_W     = 15;
    localparam int SCL_SH_A  = 14;
    localparam int SCL_SH_B  = 13;
    localparam int SCL_SH_C  = 10;
    localparam int SCALE_100 = (1 << SCL_SH_A) + (1 << SCL_SH_B) + (1 << SCL_SH_C);
    localparam int NUM_W     = SUM_W + VAL_W;
    localparam int STEP_W    = $clog2(VAL_W);

    localparam int RING_W = PRICE_BITS + 1;

    localparam int QDEPTH = 2;
    localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                  neg;
        logic [PRICE_BITS-1:0] mag;
    } t_change;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] gain;
        logic [SUM_W-1:0] loss;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_UPD  = 3'b100
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PREP = 4'b0010,
        B_DIV  = 4'b0100,
        B_DONE = 4'b1000
    } t_bstate;

    // Period register saturated into 1 .. MAX_PERIOD.
    function automatic logic [CNT_W-1:0] eff_period(input logic [CFG_W-1:0] p);
        logic [CFG_W+CNT_W-1:0] w;
        w = {{CNT_W{1'b0}}, p};
        if (w == '0) begin
            return CNT_W'(1);
        end else if (w > (CFG_W+CNT_W)'(MAX_PERIOD)) begin
            return CNT_W'(MAX_PERIOD);
        end else begin
            return w[CNT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/rrsi_ram.sv
`default_nettype none

module rrsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/rrsi_front.sv
`default_nettype none

module rrsi_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [rrsi_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_series_start,
    input  wire logic [rrsi_pkg::PRICE_BITS-1:0] i_price,
    output rrsi_pkg::t_job                      o_job,
    output logic                                o_push,
    input  wire logic                           i_full
);

    import rrsi_pkg::*;

    t_fstate               r_state, n_state;
    logic [CFG_W-1:0]      r_period;
    logic [PRICE_BITS-1:0] r_last, r_price;
    logic                  r_have_last, r_first;
    logic [SUM_W-1:0]      r_gain, r_loss, n_gain, n_loss;
    logic [PTR_W-1:0]      r_ptr, n_ptr, r_old_idx, acc_old_idx;
    logic [CNT_W-1:0]      r_count, n_count, per;
    logic [CNT_W:0]        ptr_ext, per_ext, idx_wide;

    t_change               old_chg, new_chg;
    logic [RING_W-1:0]     ram_rdata;
    logic                  accept, evict, commit, ring_we;
    logic [PRICE_BITS-1:0] gain_sub, loss_sub, gain_add, loss_add;

    assign per    = eff_period(r_period);
    assign accept = (r_state == F_IDLE) && i_in_valid;
    assign commit = (r_state == F_UPD) && !i_full;
    assign o_in_stall = (r_state != F_IDLE);

    // Ring slot that leaves the window: ptr - period, wrapped.
    always_comb begin
        ptr_ext = (CNT_W+1)'(r_ptr);
        per_ext = (CNT_W+1)'(per);
        if (ptr_ext >= per_ext) begin
            idx_wide = ptr_ext - per_ext;
        end else begin
            idx_wide = ptr_ext + (CNT_W+1)'(MAX_PERIOD) - per_ext;
        end
        acc_old_idx = idx_wide[PTR_W-1:0];
    end

    rrsi_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_ptr),
        .i_wdata (new_chg),
        .i_re    (r_state == F_READ),
        .i_raddr (r_old_idx),
        .o_rdata (ram_rdata)
    );

    assign old_chg = t_change'(ram_rdata);

    always_comb begin
        new_chg.neg = (r_price < r_last);
        new_chg.mag = new_chg.neg ? (r_last - r_price) : (r_price - r_last);

        evict    = (r_count >= per);
        gain_sub = (evict && !old_chg.neg) ? old_chg.mag : '0;
        loss_sub = (evict &&  old_chg.neg) ? old_chg.mag : '0;
        gain_add = new_chg.neg ? '0 : new_chg.mag;
        loss_add = new_chg.neg ? new_chg.mag : '0;

        if (r_first) begin
            n_gain  = '0;
            n_loss  = '0;
            n_count = '0;
            n_ptr   = '0;
        end else begin
            n_gain  = r_gain - SUM_W'(gain_sub) + SUM_W'(gain_add);
            n_loss  = r_loss - SUM_W'(loss_sub) + SUM_W'(loss_add);
            n_count = evict ? r_count : r_count + CNT_W'(1);
            n_ptr   = (r_ptr == PTR_W'(MAX_PERIOD - 1)) ? '0 : r_ptr + PTR_W'(1);
        end

        ring_we     = commit && !r_first;
        o_push      = commit;
        o_job.valid = !r_first && (n_count >= per);
        o_job.gain  = n_gain;
        o_job.loss  = n_loss;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_READ;
            F_READ: n_state = F_UPD;
            F_UPD:  if (commit) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_period    <= CFG_W'(PERIOD_RST);
            r_last      <= '0;
            r_have_last <= 1'b0;
            r_gain      <= '0;
            r_loss      <= '0;
            r_ptr       <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_last      <= r_price;
                r_have_last <= 1'b1;
                r_gain      <= n_gain;
                r_loss      <= n_loss;
                r_ptr       <= n_ptr;
                r_count     <= n_count;
            end
            // A period write empties the window but keeps the last price.
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
                r_gain   <= '0;
                r_loss   <= '0;
                r_count  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_price   <= i_price;
            r_first   <= i_series_start || !r_have_last;
            r_old_idx <= acc_old_idx;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rrsi_queue.sv
`default_nettype none

module rrsi_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rrsi_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output rrsi_pkg::t_job      o_job
);

    import rrsi_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QA_W-1:0]  r_wp, r_rp;
    logic [QC_W-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == QC_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QA_W'(QDEPTH - 1)) ? '0 : r_wp + QA_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QA_W'(QDEPTH - 1)) ? '0 : r_rp + QA_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rrsi_back.sv
`default_nettype none

module rrsi_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_job_valid,
    input  wire rrsi_pkg::t_job            i_job,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_rsi_valid,
    output logic [rrsi_pkg::VAL_W-1:0]     o_rsi_value
);

    import rrsi_pkg::*;

    t_bstate           r_state, n_state;
    logic [SUM_W-1:0]  r_gain, r_loss, r_den, r_rem;
    logic [VAL_W-1:0]  r_nlo, r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_res_valid;
    logic              r_out_valid, r_out_rsi_valid;
    logic [VAL_W-1:0]  r_out_value;

    logic [NUM_W-1:0]  num;
    logic [SUM_W:0]    trial, den_ext;
    logic              fits, out_free, last_step;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == B_IDLE) && i_job_valid;
    assign last_step = (r_step == STEP_W'(VAL_W - 1));

    // gain * 25600 by shifts and adds.
    assign num = (NUM_W'(r_gain) << SCL_SH_A) + (NUM_W'(r_gain) << SCL_SH_B)
               + (NUM_W'(r_gain) << SCL_SH_C);

    // One restoring division step: the remainder always stays below the divisor.
    assign trial   = {r_rem, r_nlo[VAL_W-1]};
    assign den_ext = {1'b0, r_den};
    assign fits    = (trial >= den_ext);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.valid && (i_job.loss != '0)) n_state = B_PREP;
                    else n_state = B_DONE;
                end
            end
            B_PREP: n_state = B_DIV;
            B_DIV:  if (last_step) n_state = B_DONE;
            B_DONE: if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_gain      <= i_job.gain;
                r_loss      <= i_job.loss;
                r_res_valid <= i_job.valid;
                r_step      <= '0;
                if (!i_job.valid) begin
                    r_quo <= '0;
                end else begin
                    r_quo <= VAL_W'(SCALE_100);
                end
            end
            B_PREP: begin
                r_den <= r_gain + r_loss;
                r_rem <= num[NUM_W-1:VAL_W];
                r_nlo <= num[VAL_W-1:0];
                r_quo <= '0;
            end
            B_DIV: begin
                r_rem  <= fits ? SUM_W'(trial - den_ext) : trial[SUM_W-1:0];
                r_nlo  <= {r_nlo[VAL_W-2:0], 1'b0};
                r_quo  <= {r_quo[VAL_W-2:0], fits};
                r_step <= r_step + STEP_W'(1);
            end
            B_DONE: begin
                if (out_free) begin
                    r_out_rsi_valid <= r_res_valid;
                    r_out_value     <= r_quo;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_rsi_valid = r_out_rsi_valid;
    assign o_rsi_value = r_out_value;

endmodule

`default_nettype wire

// File: hdl/rolling_rsi_indicator_core.sv
`default_nettype none

// Rolling RSI over a window of 1 to 64 price changes, one result per price,
// value = floor(25600 * G / (G + L)) or 25600 when there are no losses. The
// front end handles a price by accept, read of the leaving change from the
// 64-entry ring memory, and sum update, taking no new price until the update
// is pushed into the two-entry queue that hands the sums to the back end. A
// valid result with losses goes through the 15-step restoring divider in the
// back end; invalid results and loss-free windows skip it. The back end takes
// a new job only after the last result has left for the output.
// The ring needs no clearing pass after reset. Write the period only while idle.

module rolling_rsi_indicator_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [rrsi_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_series_start,
    input  wire logic [rrsi_pkg::PRICE_BITS-1:0] i_price,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_rsi_valid,
    output logic [rrsi_pkg::VAL_W-1:0]           o_rsi_value
);

    import rrsi_pkg::*;

    t_job push_job, pop_job;
    logic push, full, pop, q_valid;

    rrsi_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_series_start (i_series_start),
        .i_price        (i_price),
        .o_job          (push_job),
        .o_push         (push),
        .i_full         (full)
    );

    rrsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    rrsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsi_valid (o_rsi_valid),
        .o_rsi_value (o_rsi_value)
    );

endmodule

`default_nettype wire

// File: hdl/rrsi_chk.sv
`default_nettype none

module rrsi_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_wr_en,
    input wire logic [rrsi_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           i_series_start,
    input wire logic [rrsi_pkg::PRICE_BITS-1:0] i_price,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic                           o_rsi_valid,
    input wire logic [rrsi_pkg::VAL_W-1:0]      o_rsi_value
);

    import rrsi_pkg::*;

    // A result waiting on the consumer must not move.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_rsi_valid) && $stable(o_rsi_value)))
        else $error("result changed while stalled");

    // An incomplete window always reports zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rsi_valid) |-> (o_rsi_value == '0))
        else $error("invalid result with nonzero value");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rsi_value <= VAL_W'(SCALE_100)))
        else $error("RSI value above full scale");

    // Out of reset the block is empty and ready for a transfer.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_in_stall && !o_out_valid))
        else $error("block not empty after reset");

endmodule

bind rolling_rsi_indicator_core rrsi_chk u_rrsi_chk (.*);

`default_nettype wire
